### rtl/core/nhp_pkg.sv
// Shared constants, types and helpers for the heading and position sentence parser.
package nhp_pkg;

    // Number format
    localparam int FRACTION_DIGITS = 6;
    localparam int INTEGRAL_DIGITS = 5;

    // Elaboration-time power of ten, wide enough for the combined digit count
    function automatic longint pow10(input int n);
        longint p;
        p = 1;
        for (int i = 0; i < n; i++)
        begin
            p = p * 10;
        end
        return p;
    endfunction

    localparam longint INT_LIM   = pow10(INTEGRAL_DIGITS) - 1;
    localparam longint SCALE     = pow10(FRACTION_DIGITS);
    localparam longint VAL_LIM   = pow10(INTEGRAL_DIGITS + FRACTION_DIGITS) - 1;
    // Largest fraction sum: every digit byte at its top code (255 - 48)
    localparam longint FRAC_MAX  = 207 * ((SCALE - 1) / 9);
    localparam longint TOP_WGT   = pow10(FRACTION_DIGITS - 1);

    localparam int DIGIT_W   = 9;
    localparam int INT_W     = $clog2(INT_LIM + 1) + 1;
    localparam int INT_EXT_W = $clog2(INT_LIM * 10 + 208) + 1;
    localparam int FRAC_W    = $clog2(FRAC_MAX + 1) + 1;
    localparam int WEIGHT_W  = $clog2(TOP_WGT + 1);
    localparam int FD_W      = $clog2(FRACTION_DIGITS + 1);
    localparam int PROD_W    = $clog2(INT_LIM * SCALE + 1) + 1;
    localparam int SUM_W     = $clog2(INT_LIM * SCALE + FRAC_MAX + 1) + 1;
    localparam int VALUE_W   = 38;
    localparam int WIDE_W    = (SUM_W > VALUE_W) ? SUM_W : VALUE_W;
    localparam int FIELD_W   = 4;

    // Job queue between parser front and value back end
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Sentence bytes
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_H      = 8'h48;
    localparam logic [7:0] CHAR_POINT  = 8'h2E;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_S      = 8'h53;
    localparam logic [7:0] CHAR_W      = 8'h57;
    localparam logic [7:0] CHAR_ZERO   = 8'd48;

    // Field numbers in position sentences
    localparam logic [FIELD_W-1:0] LAT_FIELD  = 4'd3;
    localparam logic [FIELD_W-1:0] LON_FIELD  = 4'd5;
    localparam logic [FIELD_W-1:0] LAT_SIGN   = 4'd4;
    localparam logic [FIELD_W-1:0] FIELD_MAX  = 4'd15;

    // Sentence mode register codes
    localparam logic MODE_HEADING  = 1'b0;
    localparam logic MODE_POSITION = 1'b1;

    typedef enum logic [1:0] {
        KIND_HEADING = 2'd0,
        KIND_LAT     = 2'd1,
        KIND_LON     = 2'd2
    } kind_t;

    // One finished field waiting for scaling, clamping and sign
    typedef struct packed {
        kind_t                      kind;
        logic                       negate;
        logic signed [INT_W-1:0]    integral;
        logic signed [FRAC_W-1:0]   fraction;
    } job_t;

    // Weight of the k-th fraction digit: 10^(FRACTION_DIGITS-1-k)
    function automatic logic [WEIGHT_W-1:0] frac_weight(input logic [FD_W-1:0] k);
        logic [WEIGHT_W-1:0] w;
        longint              p;
        w = '0;
        p = 1;
        for (int i = FRACTION_DIGITS - 1; i >= 0; i--)
        begin
            if (k == FD_W'(i))
            begin
                w = WEIGHT_W'(p);
            end
            p = p * 10;
        end
        return w;
    endfunction

endpackage

### rtl/core/nhp_front.sv
// Byte classifier and field accumulator: tracks sentence state and issues value jobs.
module nhp_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_write,
    input  logic          cfg_data,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [7:0]    char_byte,
    input  logic          queue_full,
    output logic          job_push,
    output nhp_pkg::job_t job
);
    import nhp_pkg::*;

    logic                      mode_reg;
    logic [FIELD_W-1:0]        field_count_reg, field_count_next;
    logic                      after_start_reg, after_start_next;
    logic                      heading_reg, heading_next;
    logic signed [INT_W-1:0]   integral_reg, integral_next;
    logic signed [FRAC_W-1:0]  fraction_reg, fraction_next;
    logic [FD_W-1:0]           frac_digits_reg, frac_digits_next;
    logic                      seen_point_reg, seen_point_next;
    logic                      value_done_reg, value_done_next;
    logic                      pending_valid_reg, pending_valid_next;
    logic signed [INT_W-1:0]   pend_int_reg, pend_int_next;
    logic signed [FRAC_W-1:0]  pend_frac_reg, pend_frac_next;

    localparam logic signed [INT_EXT_W-1:0] TEN       = INT_EXT_W'(10);
    localparam logic signed [INT_EXT_W-1:0] INT_LIM_S = INT_EXT_W'(INT_LIM);

    logic                        accept;
    logic                        is_dollar;
    logic                        is_comma;
    logic                        head_now;
    logic                        num_field;
    logic                        lat_sign;
    logic signed [DIGIT_W-1:0]   digit;
    logic signed [INT_EXT_W-1:0] int_wide;
    logic signed [INT_W-1:0]     int_sat;
    logic signed [FRAC_W-1:0]    frac_add;

    assign in_stall  = queue_full;
    assign accept    = in_valid && !queue_full;
    assign is_dollar = (char_byte == CHAR_DOLLAR);
    assign is_comma  = (char_byte == CHAR_COMMA);
    assign head_now  = after_start_reg ? (char_byte == CHAR_H) : heading_reg;
    assign num_field = (field_count_reg == LAT_FIELD) || (field_count_reg == LON_FIELD);
    assign lat_sign  = (field_count_reg == LAT_SIGN);
    assign digit     = $signed({1'b0, char_byte}) - $signed({1'b0, CHAR_ZERO});

    // integral*10 + digit, held to the integral limit
    always_comb
    begin
        int_wide = INT_EXT_W'(integral_reg) * TEN + INT_EXT_W'(digit);
        priority if (int_wide > INT_LIM_S)
        begin
            int_sat = INT_W'(INT_LIM_S);
        end
        else if (int_wide < -INT_LIM_S)
        begin
            int_sat = INT_W'(-INT_LIM_S);
        end
        else
        begin
            int_sat = INT_W'(int_wide);
        end
    end

    assign frac_add = FRAC_W'(digit)
                    * FRAC_W'($signed({1'b0, frac_weight(frac_digits_reg)}));

    always_comb
    begin
        field_count_next   = field_count_reg;
        after_start_next   = after_start_reg;
        heading_next       = heading_reg;
        integral_next      = integral_reg;
        fraction_next      = fraction_reg;
        frac_digits_next   = frac_digits_reg;
        seen_point_next    = seen_point_reg;
        value_done_next    = value_done_reg;
        pending_valid_next = pending_valid_reg;
        pend_int_next      = pend_int_reg;
        pend_frac_next     = pend_frac_reg;
        job_push           = 1'b0;
        job.kind           = KIND_HEADING;
        job.negate         = 1'b0;
        job.integral       = integral_reg;
        job.fraction       = fraction_reg;

        if (accept)
        begin
            if (is_dollar)
            begin
                // Start of sentence: drop everything
                field_count_next   = '0;
                after_start_next   = 1'b1;
                heading_next       = 1'b0;
                integral_next      = '0;
                fraction_next      = '0;
                frac_digits_next   = '0;
                seen_point_next    = 1'b0;
                value_done_next    = 1'b0;
                pending_valid_next = 1'b0;
            end
            else
            begin
                after_start_next = 1'b0;
                heading_next     = head_now;

                // The byte after a stored position field carries its sign
                if (mode_reg == MODE_POSITION && pending_valid_reg)
                begin
                    job_push           = 1'b1;
                    job.kind           = lat_sign ? KIND_LAT : KIND_LON;
                    job.negate         = lat_sign ? (char_byte == CHAR_S)
                                                  : (char_byte == CHAR_W);
                    job.integral       = pend_int_reg;
                    job.fraction       = pend_frac_reg;
                    pending_valid_next = 1'b0;
                end

                if (is_comma)
                begin
                    if (mode_reg == MODE_HEADING)
                    begin
                        if (head_now && seen_point_reg && !value_done_reg)
                        begin
                            job_push        = 1'b1;
                            job.kind        = KIND_HEADING;
                            job.negate      = 1'b0;
                            job.integral    = integral_reg;
                            job.fraction    = fraction_reg;
                            value_done_next = 1'b1;
                        end
                    end
                    else if (num_field)
                    begin
                        pend_int_next      = integral_reg;
                        pend_frac_next     = fraction_reg;
                        pending_valid_next = 1'b1;
                    end
                    integral_next    = '0;
                    fraction_next    = '0;
                    frac_digits_next = '0;
                    seen_point_next  = 1'b0;
                    if (field_count_reg != FIELD_MAX)
                    begin
                        field_count_next = field_count_reg + 1'b1;
                    end
                end
                else if (mode_reg == MODE_HEADING || num_field)
                begin
                    priority if (char_byte == CHAR_POINT && !seen_point_reg)
                    begin
                        seen_point_next = 1'b1;
                    end
                    else if (!seen_point_reg)
                    begin
                        integral_next = int_sat;
                    end
                    else if (frac_digits_reg < FD_W'(FRACTION_DIGITS))
                    begin
                        fraction_next    = fraction_reg + frac_add;
                        frac_digits_next = frac_digits_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_HEADING;
            field_count_reg   <= '0;
            after_start_reg   <= 1'b0;
            heading_reg       <= 1'b0;
            integral_reg      <= '0;
            fraction_reg      <= '0;
            frac_digits_reg   <= '0;
            seen_point_reg    <= 1'b0;
            value_done_reg    <= 1'b0;
            pending_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                mode_reg <= cfg_data;
            end
            field_count_reg   <= field_count_next;
            after_start_reg   <= after_start_next;
            heading_reg       <= heading_next;
            integral_reg      <= integral_next;
            fraction_reg      <= fraction_next;
            frac_digits_reg   <= frac_digits_next;
            seen_point_reg    <= seen_point_next;
            value_done_reg    <= value_done_next;
            pending_valid_reg <= pending_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_int_reg  <= pend_int_next;
        pend_frac_reg <= pend_frac_next;
    end

    a_dollar_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_dollar) |=> (after_start_reg && field_count_reg == '0
                                   && !pending_valid_reg && !seen_point_reg))
        else $error("sentence start did not clear parser state");

    a_frac_needs_point: assert property (@(posedge clk) disable iff (!rst_n)
        !seen_point_reg |-> (frac_digits_reg == '0))
        else $error("fraction digits counted without a point");

    a_position_job_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (job_push && job.kind != KIND_HEADING) |-> (mode_reg == MODE_POSITION))
        else $error("position value issued in heading mode");

endmodule

### rtl/core/nhp_queue.sv
// Short job queue between the parser front and the value back end.
module nhp_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  nhp_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output nhp_pkg::job_t head_job
);
    import nhp_pkg::*;

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("job pushed into a full queue");

endmodule

### rtl/core/nhp_back.sv
// Value back end: scale, add fraction, clamp, apply sign, hold result for output.
module nhp_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              job_valid,
    input  nhp_pkg::job_t                     job,
    output logic                              job_pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        value_kind,
    output logic signed [nhp_pkg::VALUE_W-1:0] value_micro
);
    import nhp_pkg::*;

    localparam logic signed [PROD_W-1:0] SCALE_S = PROD_W'(SCALE);
    localparam logic signed [WIDE_W-1:0] VAL_LIM_S = WIDE_W'(VAL_LIM);

    // Stage 1: integral scaled
    logic                      s1_valid_reg, s1_valid_next;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [FRAC_W-1:0]  s1_frac_reg;
    kind_t                     s1_kind_reg;
    logic                      s1_neg_reg;

    // Stage 2: output register
    logic                      out_valid_reg, out_valid_next;
    kind_t                     out_kind_reg;
    logic signed [VALUE_W-1:0] out_value_reg;

    logic                      s2_free;
    logic                      s1_free;
    logic signed [WIDE_W-1:0]  sum;
    logic signed [WIDE_W-1:0]  clamped;
    logic signed [WIDE_W-1:0]  signed_val;

    assign s2_free = !out_valid_reg || !out_stall;
    assign s1_free = !s1_valid_reg || s2_free;
    assign job_pop = job_valid && s1_free;

    assign s1_valid_next  = job_pop || (s1_valid_reg && !s2_free);
    assign out_valid_next = s2_free ? s1_valid_reg : out_valid_reg;

    always_comb
    begin
        sum = WIDE_W'(prod_reg) + WIDE_W'(s1_frac_reg);
        priority if (sum > VAL_LIM_S)
        begin
            clamped = VAL_LIM_S;
        end
        else if (sum < -VAL_LIM_S)
        begin
            clamped = -VAL_LIM_S;
        end
        else
        begin
            clamped = sum;
        end
        signed_val = s1_neg_reg ? -clamped : clamped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            prod_reg    <= PROD_W'(job.integral) * SCALE_S;
            s1_frac_reg <= job.fraction;
            s1_kind_reg <= job.kind;
            s1_neg_reg  <= job.negate;
        end
        if (s2_free && s1_valid_reg)
        begin
            out_kind_reg  <= s1_kind_reg;
            out_value_reg <= signed_val[VALUE_W-1:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign value_kind  = out_kind_reg;
    assign value_micro = out_value_reg;

    a_pop_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |=> s1_valid_reg)
        else $error("popped job lost before scaling stage");

endmodule

### rtl/core/nmea_heading_position_parser.sv
// Top level of the heading and position sentence parser.
//
//  Channel   Direction  Handshake              Payload
//  -------   ---------  ---------------------  ---------------------------------
//  input     in         in_valid / in_stall    char_byte[7:0]
//  output    out        out_valid / out_stall  value_kind[1:0], value_micro[37:0]
//  config    in         cfg_write              cfg_data (sentence mode)
//
// One byte is taken every cycle while the job queue has room; in_stall is the
// queue-full flag. A byte that finishes a value reaches out_valid by way of the
// queue slot, then the scaling multiply, then add and clamp into the output
// register.
// Reset is asynchronous and clears all sentence state and the mode register;
// there is no clearing pass, so bytes are taken from the first cycle after reset.
// A stall on the output holds the output register, then the scaling stage, then
// fills the two-entry queue before the input stalls.
module nmea_heading_position_parser (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic                               cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [7:0]                         char_byte,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         value_kind,
    output logic signed [nhp_pkg::VALUE_W-1:0] value_micro
);
    import nhp_pkg::*;

    // Front to queue
    logic  job_push;
    job_t  front_job;
    logic  queue_full;

    // Queue to back end
    logic  head_valid;
    job_t  head_job;
    logic  job_pop;

    // Classify each byte, keep field accumulators, issue a job per finished value
    nhp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_byte  (char_byte),
        .queue_full (queue_full),
        .job_push   (job_push),
        .job        (front_job)
    );

    // Decouple the front from output back-pressure
    nhp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_push),
        .push_job   (front_job),
        .full       (queue_full),
        .pop        (job_pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // Scale to micro units, clamp, apply sign, hold the result transaction
    nhp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (head_valid),
        .job         (head_job),
        .job_pop     (job_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .value_kind  (value_kind),
        .value_micro (value_micro)
    );

endmodule
